>>> hw/rtl/acdl_pkg.sv
// Package for the ADC change detector with resistor-ladder switch decode.
// Holds widths, reset values, the ladder threshold table and shared types.
// No dependencies.
package acdl_pkg;

  localparam int unsigned POT_CHANNELS = 3;
  localparam int unsigned LADDER_STEPS = 16;

  localparam int unsigned SampleW  = 8;
  localparam int unsigned CodeW    = 4;
  localparam int unsigned ChannelW = 2;
  localparam int unsigned CfgIdxW  = 1;
  localparam int unsigned CfgDataW = 8;

  localparam logic [ChannelW-1:0] LADDER_CHANNEL = 2'd3;
  localparam logic [SampleW-1:0]  LADDER_SAMPLE_RESET = 8'd12;
  localparam logic [SampleW-1:0]  DEADBAND_RESET  = 8'd8;
  localparam logic [SampleW-1:0]  TOLERANCE_RESET = 8'd1;

  // Command codes carried in the input tuser
  localparam logic CMD_SAMPLE  = 1'b0;
  localparam logic CMD_REFRESH = 1'b1;

  // Configuration register indexes
  localparam logic [CfgIdxW-1:0] REG_POT_DEADBAND     = 1'd0;
  localparam logic [CfgIdxW-1:0] REG_SWITCH_TOLERANCE = 1'd1;

  typedef logic [SampleW-1:0] ladder_table_t [16];

  // Midpoints between adjacent ladder switch levels
  localparam ladder_table_t LADDER_THRESHOLD = '{
    8'd0,   8'd4,   8'd16,  8'd27,  8'd38,  8'd49,  8'd59,  8'd69,
    8'd81,  8'd93,  8'd102, 8'd110, 8'd117, 8'd125, 8'd132, 8'd139
  };

  typedef struct packed {
    logic                cmd;
    logic [ChannelW-1:0] channel;
    logic [SampleW-1:0]  sample_high;
    logic                sample_low_bit;
  } item_t;

  typedef struct packed {
    logic [SampleW-1:0] pot_deadband;
    logic [SampleW-1:0] switch_tolerance;
  } cfg_t;

  typedef logic [SampleW-1:0] pot_levels_t [POT_CHANNELS];

  typedef struct packed {
    logic               has_result;
    logic [SampleW-1:0] value;
    logic               changed;
  } result_t;

  function automatic logic [SampleW-1:0] abs_diff(input logic [SampleW-1:0] a,
                                                  input logic [SampleW-1:0] b);
    abs_diff = (a > b) ? (a - b) : (b - a);
  endfunction

endpackage

>>> hw/rtl/acdl_core.sv
// Single-pass qualification logic: deadband check, ladder decode and next state.
// Purely combinational; uses acdl_pkg.
module acdl_core (
  input  acdl_pkg::item_t                  item,
  input  acdl_pkg::cfg_t                   cfg,
  input  acdl_pkg::pot_levels_t            pot_level,
  input  logic [acdl_pkg::CodeW-1:0]       switch_code,
  input  logic [acdl_pkg::SampleW-1:0]     previous_ladder_sample,
  output acdl_pkg::pot_levels_t            pot_level_next,
  output logic [acdl_pkg::CodeW-1:0]       switch_code_next,
  output logic [acdl_pkg::SampleW-1:0]     previous_ladder_sample_next,
  output acdl_pkg::result_t                result
);

  logic [acdl_pkg::SampleW-1:0] ladder_value;
  logic [acdl_pkg::SampleW-1:0] ladder_diff;
  logic [acdl_pkg::CodeW-1:0]   decoded;
  logic                         ladder_stable;

  assign ladder_value = {item.sample_high[acdl_pkg::SampleW-2:0], item.sample_low_bit};
  assign ladder_diff  = acdl_pkg::abs_diff(previous_ladder_sample, ladder_value);
  assign ladder_stable = (ladder_diff <= cfg.switch_tolerance);

  // Largest index whose threshold is at or below the value; index 0 always matches
  always_comb begin
    decoded = '0;
    for (int i = 0; i < int'(acdl_pkg::LADDER_STEPS); i++) begin
      if (acdl_pkg::LADDER_THRESHOLD[i] <= ladder_value) begin
        decoded = acdl_pkg::CodeW'(i);
      end
    end
  end

  always_comb begin
    pot_level_next              = pot_level;
    switch_code_next            = switch_code;
    previous_ladder_sample_next = previous_ladder_sample;
    result.has_result           = 1'b1;
    result.value                = item.sample_high;
    result.changed              = 1'b0;

    if (item.cmd == acdl_pkg::CMD_REFRESH) begin
      for (int i = 0; i < int'(acdl_pkg::POT_CHANNELS); i++) begin
        pot_level_next[i] = ~pot_level[i];
      end
      switch_code_next  = ~switch_code;
      result.has_result = 1'b0;
    end else if (item.channel == acdl_pkg::LADDER_CHANNEL) begin
      previous_ladder_sample_next = ladder_value;
      if (!ladder_stable) begin
        result.value = acdl_pkg::SampleW'(switch_code);
      end else begin
        result.value = acdl_pkg::SampleW'(decoded);
        if (decoded != switch_code) begin
          switch_code_next = decoded;
          result.changed   = 1'b1;
        end
      end
    end else begin
      for (int i = 0; i < int'(acdl_pkg::POT_CHANNELS); i++) begin
        if (int'(item.channel) == i &&
            acdl_pkg::abs_diff(pot_level[i], item.sample_high) > cfg.pot_deadband) begin
          pot_level_next[i] = item.sample_high;
          result.changed    = 1'b1;
        end
      end
    end
  end

endmodule

>>> hw/rtl/adc_change_detect_ladder_decode.sv
// An input transaction is held in the input register, then its result in the result register.
// Throughput: one item per cycle unless the result side stalls; the input register and result
// register decouple the two sides, so a waiting result does not block a refresh.
// Refresh commands produce no result transaction.
// Reset (synchronous, rst high): stored levels and code cleared, previous ladder
// sample 12, deadband 8, tolerance 1, both stages empty. Uses acdl_pkg, acdl_core.
module adc_change_detect_ladder_decode (
  input  logic        clk,
  input  logic        rst,
  // configuration writes
  input  logic                          cfg_we,
  input  logic [acdl_pkg::CfgIdxW-1:0]  cfg_index,
  input  logic [acdl_pkg::CfgDataW-1:0] cfg_data,
  // input stream
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [15:0] s_tdata,   // [7:0] sample_high, [8] sample_low_bit, rest zero
  input  logic [2:0]  s_tuser,   // [0] cmd, [2:1] channel
  // result stream
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [15:0] m_tdata    // [7:0] value, [8] changed, rest zero
);

  acdl_pkg::cfg_t        cfg;
  acdl_pkg::item_t       item;
  logic                  item_valid;
  acdl_pkg::pot_levels_t pot_level;
  acdl_pkg::pot_levels_t pot_level_next;
  logic [acdl_pkg::CodeW-1:0]   switch_code;
  logic [acdl_pkg::CodeW-1:0]   switch_code_next;
  logic [acdl_pkg::SampleW-1:0] previous_ladder_sample;
  logic [acdl_pkg::SampleW-1:0] previous_ladder_sample_next;
  acdl_pkg::result_t     result;
  logic [acdl_pkg::SampleW-1:0] out_value;
  logic                  out_changed;
  logic                  out_free;
  logic                  advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.pot_deadband     <= acdl_pkg::DEADBAND_RESET;
      cfg.switch_tolerance <= acdl_pkg::TOLERANCE_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        acdl_pkg::REG_POT_DEADBAND:     cfg.pot_deadband     <= cfg_data;
        acdl_pkg::REG_SWITCH_TOLERANCE: cfg.switch_tolerance <= cfg_data;
        default: ;
      endcase
    end
  end

  // A refresh leaves nothing for the result register, so it never waits on it
  assign out_free = !m_tvalid || m_tready;
  assign advance  = item_valid && (result.has_result ? out_free : 1'b1);
  assign s_tready = !item_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else if (s_tready) begin
      item_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tready && s_tvalid) begin
      item.cmd            <= s_tuser[0];
      item.channel        <= s_tuser[2:1];
      item.sample_high    <= s_tdata[7:0];
      item.sample_low_bit <= s_tdata[8];
    end
  end

  acdl_core u_core (
    .item                        (item),
    .cfg                         (cfg),
    .pot_level                   (pot_level),
    .switch_code                 (switch_code),
    .previous_ladder_sample      (previous_ladder_sample),
    .pot_level_next              (pot_level_next),
    .switch_code_next            (switch_code_next),
    .previous_ladder_sample_next (previous_ladder_sample_next),
    .result                      (result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < int'(acdl_pkg::POT_CHANNELS); i++) begin
        pot_level[i] <= '0;
      end
      switch_code            <= '0;
      previous_ladder_sample <= acdl_pkg::LADDER_SAMPLE_RESET;
    end else if (advance) begin
      pot_level              <= pot_level_next;
      switch_code            <= switch_code_next;
      previous_ladder_sample <= previous_ladder_sample_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (out_free) begin
      m_tvalid <= advance && result.has_result;
    end
  end

  always_ff @(posedge clk) begin
    if (out_free && advance && result.has_result) begin
      out_value   <= result.value;
      out_changed <= result.changed;
    end
  end

  assign m_tdata = {7'b0, out_changed, out_value};

endmodule

>>> hw/rtl/acdl_checker.sv
// Port-level checks for adc_change_detect_ladder_decode, bound to the top level.
// Uses only the top-level ports.
module acdl_checker (
  input logic        clk,
  input logic        rst,
  input logic        s_tvalid,
  input logic        s_tready,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [15:0] m_tdata
);

  // A stalled result keeps its payload
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("result changed while stalled");

  a_reset_empty: assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("result valid right after reset");

  // With the result register empty the input side cannot be stalled
  a_no_false_stall: assert property (@(posedge clk) disable iff (rst)
    !m_tvalid |-> s_tready)
    else $error("input stalled with empty result register");

  // A fresh result follows an input transaction through the input and result registers
  a_result_origin: assert property (@(posedge clk) disable iff (rst)
    $rose(m_tvalid) |-> $past(s_tvalid && s_tready, 2))
    else $error("result without a matching input transaction");

endmodule

bind adc_change_detect_ladder_decode acdl_checker u_acdl_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata)
);

>>> tb/tb_top.sv
// Self-checking bench for adc_change_detect_ladder_decode: directed table, then random
// phases under several deadband/tolerance settings. Depends on acdl_pkg and the block RTL.
module tb_top;

  localparam int CYCLE_LIMIT = 400000;
  localparam int PHASE_ITEMS = 270;
  localparam int NUM_SETTINGS = 6;
  localparam int RX_HOLD_CYCLES = 90;
  localparam int DRAIN_SLACK = 4;

  // ladder midpoints, index 0 in the low byte
  localparam logic [15:0][7:0] LADDER_MID = {
    8'd139, 8'd132, 8'd125, 8'd117, 8'd110, 8'd102, 8'd93, 8'd81,
    8'd69,  8'd59,  8'd49,  8'd38,  8'd27,  8'd16,  8'd4,  8'd0
  };

  typedef struct packed {
    logic [7:0] value;
    logic       changed;
  } report_t;

  typedef struct packed {
    logic       cmd;
    logic [1:0] channel;
    logic [7:0] high;
    logic       low;
    logic       typed;
    logic [7:0] want_value;
    logic       want_changed;
  } stim_row_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_we;
  logic [acdl_pkg::CfgIdxW-1:0]  cfg_index;
  logic [acdl_pkg::CfgDataW-1:0] cfg_data;
  logic        s_tvalid;
  logic        s_tready;
  logic [15:0] s_tdata;   // [7:0] sample_high, [8] sample_low_bit, rest zero
  logic [2:0]  s_tuser;   // [0] cmd, [2:1] channel
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [15:0] m_tdata;   // [7:0] value, [8] changed, rest zero

  always #10 clk = ~clk;

  adc_change_detect_ladder_decode dut (
    .clk(clk), .rst(rst),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
  );

  // predictor state
  logic [7:0] pot_level_m [3] = '{8'd0, 8'd0, 8'd0};
  logic [3:0] code_m = 4'd0;
  logic [7:0] ladder_prev_m = 8'd12;
  logic [7:0] deadband_m = 8'd8;
  logic [7:0] tolerance_m = 8'd1;

  report_t awaited_reports [$];
  int mismatches = 0;
  int items_sent = 0, refresh_sent = 0, ladder_sent = 0;
  int results_seen = 0, changes_seen = 0;
  int cycle_count = 0;
  bit hold_req = 1'b0;
  bit rx_fast = 1'b0;

  stim_row_t directed_rows [23] = '{
    {acdl_pkg::CMD_SAMPLE,  2'd0, 8'd0,   1'b0, 1'b1, 8'd0,   1'b0},
    {acdl_pkg::CMD_SAMPLE,  2'd0, 8'd255, 1'b0, 1'b1, 8'd255, 1'b1},
    {acdl_pkg::CMD_SAMPLE,  2'd1, 8'd8,   1'b1, 1'b1, 8'd8,   1'b0},  // exactly at deadband
    {acdl_pkg::CMD_SAMPLE,  2'd1, 8'd9,   1'b0, 1'b1, 8'd9,   1'b1},
    {acdl_pkg::CMD_SAMPLE,  2'd2, 8'd128, 1'b0, 1'b1, 8'd128, 1'b1},
    {acdl_pkg::CMD_SAMPLE,  2'd3, 8'd6,   1'b0, 1'b1, 8'd1,   1'b1},  // 12 matches reset sample
    {acdl_pkg::CMD_SAMPLE,  2'd3, 8'd6,   1'b1, 1'b1, 8'd1,   1'b0},
    {acdl_pkg::CMD_SAMPLE,  2'd3, 8'd255, 1'b1, 1'b1, 8'd1,   1'b0},  // jump: old code
    {acdl_pkg::CMD_SAMPLE,  2'd3, 8'd255, 1'b1, 1'b1, 8'd15,  1'b1},
    {acdl_pkg::CMD_REFRESH, 2'd0, 8'd0,   1'b0, 1'b0, 8'd0,   1'b0},
    {acdl_pkg::CMD_SAMPLE,  2'd1, 8'd9,   1'b0, 1'b0, 8'd0,   1'b0},
    {acdl_pkg::CMD_SAMPLE,  2'd0, 8'd0,   1'b0, 1'b0, 8'd0,   1'b0},
    {acdl_pkg::CMD_SAMPLE,  2'd3, 8'd255, 1'b1, 1'b1, 8'd15,  1'b1},
    {acdl_pkg::CMD_SAMPLE,  2'd3, 8'd0,   1'b0, 1'b1, 8'd15,  1'b0},
    {acdl_pkg::CMD_SAMPLE,  2'd3, 8'd0,   1'b0, 1'b1, 8'd0,   1'b1},
    {acdl_pkg::CMD_SAMPLE,  2'd3, 8'd128, 1'b0, 1'b1, 8'd0,   1'b0},  // top bit shifted out
    {acdl_pkg::CMD_SAMPLE,  2'd3, 8'd69,  1'b1, 1'b0, 8'd0,   1'b0},
    {acdl_pkg::CMD_SAMPLE,  2'd3, 8'd69,  1'b1, 1'b0, 8'd0,   1'b0},
    {acdl_pkg::CMD_SAMPLE,  2'd3, 8'd69,  1'b0, 1'b0, 8'd0,   1'b0},
    {acdl_pkg::CMD_REFRESH, 2'd3, 8'd255, 1'b1, 1'b0, 8'd0,   1'b0},
    {acdl_pkg::CMD_REFRESH, 2'd2, 8'd0,   1'b0, 1'b0, 8'd0,   1'b0},
    {acdl_pkg::CMD_SAMPLE,  2'd2, 8'd127, 1'b0, 1'b0, 8'd0,   1'b0},
    {acdl_pkg::CMD_SAMPLE,  2'd3, 8'd197, 1'b0, 1'b0, 8'd0,   1'b0}
  };

  function automatic logic [7:0] dist8(input logic [7:0] a, input logic [7:0] b);
    return (a > b) ? a - b : b - a;
  endfunction

  // Updates the predicted state for one item; has_report is 0 for a refresh.
  task automatic qualify_conversion(input acdl_pkg::item_t it, output bit has_report,
                                    output report_t rep);
    logic [7:0] v;
    logic [3:0] code;
    has_report = 1'b1;
    rep.value = it.sample_high;
    rep.changed = 1'b0;
    if (it.cmd == acdl_pkg::CMD_REFRESH) begin
      has_report = 1'b0;
      foreach (pot_level_m[i]) pot_level_m[i] = ~pot_level_m[i];
      code_m = ~code_m;
    end else if (it.channel == acdl_pkg::LADDER_CHANNEL) begin
      v = {it.sample_high[6:0], it.sample_low_bit};
      if (dist8(ladder_prev_m, v) > tolerance_m) begin
        rep.value = {4'd0, code_m};
      end else begin
        code = 4'd0;
        for (int i = 0; i < 16; i++)
          if (LADDER_MID[i] <= v) code = 4'(i);
        rep.value = {4'd0, code};
        rep.changed = (code != code_m);
        code_m = code;
      end
      ladder_prev_m = v;
    end else if (dist8(pot_level_m[it.channel], it.sample_high) > deadband_m) begin
      pot_level_m[it.channel] = it.sample_high;
      rep.changed = 1'b1;
    end
  endtask

  task automatic send_item(input acdl_pkg::item_t it, input int gap, input bit typed,
                           input report_t typed_rep);
    bit has_report;
    report_t rep;
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser <= {it.channel, it.cmd};
    s_tdata <= {7'd0, it.sample_low_bit, it.sample_high};
    do @(posedge clk); while (!s_tready);
    items_sent++;
    if (it.cmd == acdl_pkg::CMD_REFRESH) refresh_sent++;
    else if (it.channel == acdl_pkg::LADDER_CHANNEL) ladder_sent++;
    qualify_conversion(it, has_report, rep);
    if (has_report) awaited_reports.push_back(typed ? typed_rep : rep);
  endtask

  // Stop offering and wait until every predicted report has been taken.
  task automatic drain();
    s_tvalid <= 1'b0;
    do @(posedge clk); while (awaited_reports.size() != 0);
  endtask

  // Mostly samples near the stored state so both sides of each threshold get hit.
  task automatic random_item(output acdl_pkg::item_t it);
    int r, span, x;
    r = $urandom_range(0, 99);
    it.cmd = (r < 6) ? acdl_pkg::CMD_REFRESH : acdl_pkg::CMD_SAMPLE;
    it.channel = (r >= 6 && r < 42) ? acdl_pkg::LADDER_CHANNEL : 2'($urandom_range(0, 2));
    it.sample_high = 8'($urandom_range(0, 255));
    it.sample_low_bit = 1'($urandom_range(0, 1));
    if (it.cmd == acdl_pkg::CMD_SAMPLE && $urandom_range(0, 3) != 0) begin
      if (it.channel == acdl_pkg::LADDER_CHANNEL) begin
        span = int'(tolerance_m) + 2;
        x = int'(ladder_prev_m) + int'($urandom_range(0, 2 * span)) - span;
        it.sample_high = {1'($urandom_range(0, 1)), 7'(x >> 1)};
        it.sample_low_bit = 1'(x);
      end else begin
        span = int'(deadband_m) + 2;
        x = int'(pot_level_m[it.channel]) + int'($urandom_range(0, 2 * span)) - span;
        if (x < 0) x = 0;
        if (x > 255) x = 255;
        it.sample_high = 8'(x);
      end
    end
  endtask

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("tb_top: timeout at %0t, %0d reports outstanding", $time,
               awaited_reports.size());
      $display("tb_top: FAIL");
      $finish;
    end
  end

  // result side
  initial begin
    int stall;
    report_t want;
    logic [15:0] got;
    while (rst) @(posedge clk);
    forever begin
      stall = rx_fast ? 0 : $urandom_range(0, 18);
      if (hold_req) begin
        stall = RX_HOLD_CYCLES;
        hold_req = 1'b0;
      end
      if (stall > 0) begin
        m_tready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      m_tready <= 1'b1;
      do @(posedge clk); while (!m_tvalid);
      got = m_tdata;
      results_seen++;
      if (got[8]) changes_seen++;
      if (awaited_reports.size() == 0) begin
        mismatches++;
        if (mismatches <= 25)
          $display("%0t: unexpected result transaction, got value %0d changed %0b",
                   $time, got[7:0], got[8]);
      end else begin
        want = awaited_reports.pop_front();
        if (got[7:0] !== want.value || got[8] !== want.changed || got[15:9] !== 7'd0) begin
          mismatches++;
          if (mismatches <= 25)
            $display({"%0t: mismatch, expected value %0d changed %0b pad 0,",
                      " got value %0d changed %0b pad %0h"},
                     $time, want.value, want.changed, got[7:0], got[8], got[15:9]);
        end
      end
      if (results_seen % 40 == 0) rx_fast = ($urandom_range(0, 3) == 0);
    end
  end

  // stimulus side
  initial begin
    acdl_pkg::item_t it;
    report_t typed_rep;
    stim_row_t row;
    logic [7:0] db_set [NUM_SETTINGS];
    logic [7:0] tol_set [NUM_SETTINGS];
    int gap, burst;
    bit no_idle;
    db_set = '{8'd0, 8'd255, 8'd8, 8'd3, 8'd0, 8'd200};
    tol_set = '{8'd0, 8'd255, 8'd1, 8'd6, 8'd0, 8'd0};
    s_tvalid = 1'b0;
    s_tdata = '0;
    s_tuser = '0;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    db_set[4] = 8'($urandom_range(0, 255));
    tol_set[4] = 8'($urandom_range(0, 255));
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    foreach (directed_rows[r]) begin
      row = directed_rows[r];
      it.cmd = row.cmd;
      it.channel = row.channel;
      it.sample_high = row.high;
      it.sample_low_bit = row.low;
      typed_rep.value = row.want_value;
      typed_rep.changed = row.want_changed;
      send_item(it, $urandom_range(0, 18), row.typed, typed_rep);
    end

    for (int p = 0; p < NUM_SETTINGS; p++) begin
      drain();
      // refresh items leave no report, so give the pipeline time to empty
      repeat (DRAIN_SLACK) @(posedge clk);
      cfg_we <= 1'b1;
      cfg_index <= acdl_pkg::REG_POT_DEADBAND;
      cfg_data <= db_set[p];
      @(posedge clk);
      deadband_m = db_set[p];
      cfg_index <= acdl_pkg::REG_SWITCH_TOLERANCE;
      cfg_data <= tol_set[p];
      @(posedge clk);
      tolerance_m = tol_set[p];
      cfg_we <= 1'b0;

      no_idle = 1'b0;
      burst = 0;
      for (int k = 0; k < PHASE_ITEMS; k++) begin
        // back-pressure test: receiver stalls while the sender keeps streaming
        if (p == 1 && k == 0) begin
          hold_req = 1'b1;
          burst = 30;
        end
        if (p == 3 && k == PHASE_ITEMS / 2) drain();
        if (k % 45 == 0) no_idle = ($urandom_range(0, 2) == 0);
        random_item(it);
        gap = (no_idle || burst > 0) ? 0 : $urandom_range(0, 18);
        if (burst > 0) burst--;
        send_item(it, gap, 1'b0, '0);
      end
    end

    drain();
    repeat (8) @(posedge clk);
    $display("tb_top: %0d items sent (%0d refresh, %0d ladder), six register settings",
             items_sent, refresh_sent, ladder_sent);
    $display("tb_top: %0d results checked, %0d with change flag, %0d mismatches",
             results_seen, changes_seen, mismatches);
    if (mismatches == 0) begin
      $display("tb_top: PASS");
    end else begin
      $display("tb_top: FAIL");
    end
    $finish;
  end

endmodule

>>> sim.f
hw/rtl/acdl_pkg.sv
hw/rtl/acdl_core.sv
hw/rtl/adc_change_detect_ladder_decode.sv
hw/rtl/acdl_checker.sv
tb/tb_top.sv
